// ----- hdl/three_class_priority_queue_scheduler_macros.svh -----
// Assertion macros for the three-class priority queue scheduler.
`ifndef THREE_CLASS_PRIORITY_QUEUE_SCHEDULER_MACROS_SVH
`define THREE_CLASS_PRIORITY_QUEUE_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define TCPQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcpq assertion failed");
`define TCPQ_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tcpq forbidden condition seen");
`else
`define TCPQ_ASSERT(name, clk, rst_n, prop)
`define TCPQ_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ----- hdl/tcpq_pkg.sv -----
// Shared types and constants of the three-class priority queue scheduler.
package tcpq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned NumClasses        = 3;
  localparam int unsigned DataW             = 8;
  localparam int unsigned OccW              = 6;
  localparam int unsigned LimitW            = 8;
  localparam int unsigned ApbAddrW          = 3;
  localparam int unsigned ApbDataW          = 32;

  localparam logic [LimitW-1:0]       RunLimitReset = 8'd3;
  localparam logic [LimitW-1:0]       RunCountMax   = 8'hFF;
  localparam logic signed [DataW-1:0] EmptyValue    = -8'sd1;
  localparam logic                    RegIdxRunLimit = 1'b0;

  typedef enum logic [1:0] {
    ClassNormal   = 2'd0,
    ClassPriority = 2'd1,
    ClassTop      = 2'd2,
    ClassNone     = 2'd3
  } class_e;

  typedef enum logic {
    OpEnqueue = 1'b0,
    OpDequeue = 1'b1
  } op_e;

  typedef struct packed {
    logic                    opcode;
    logic [1:0]              queue_class;
    logic signed [DataW-1:0] entry_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_value;
    logic [1:0]              served_class;
    logic                    nothing_to_serve;
    logic                    entry_accepted;
    logic                    all_empty;
    logic [OccW-1:0]         total_occupancy;
  } rsp_t;

  typedef struct packed {
    logic [NumClasses-1:0] push;
    logic [NumClasses-1:0] pop;
    class_e                served;
    logic                  nothing;
    logic                  accepted;
  } ctrl_t;

endpackage

// ----- hdl/tcpq_fifo.sv -----
// One class FIFO: storage array, wrapping pointers, fill count, registered read data.
module tcpq_fifo #(
  parameter int unsigned Depth = tcpq_pkg::QueueDepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic                             pop_i,
  input  logic signed [tcpq_pkg::DataW-1:0] wdata_i,
  output logic signed [tcpq_pkg::DataW-1:0] rdata_o,
  output logic [$clog2(Depth+1)-1:0]       count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic signed [tcpq_pkg::DataW-1:0] mem [Depth];
  logic signed [tcpq_pkg::DataW-1:0] rdata_q;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
  end

  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= wdata_i;
    end
    if (pop_i) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  assign rdata_o = rdata_q;
  assign count_o = count_q;

endmodule

// ----- hdl/tcpq_arbiter.sv -----
// Enqueue admission, strict and ratio-based dequeue choice, and the priority run counter.
module tcpq_arbiter #(
  parameter int unsigned Depth = tcpq_pkg::QueueDepthDefault
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                cmd_valid_i,
  input  tcpq_pkg::cmd_t                                      cmd_i,
  input  logic [tcpq_pkg::NumClasses-1:0][$clog2(Depth+1)-1:0] counts_i,
  input  logic [tcpq_pkg::LimitW-1:0]                         run_limit_i,
  output tcpq_pkg::ctrl_t                                     ctrl_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [tcpq_pkg::NumClasses-1:0] full, empty;
  logic [tcpq_pkg::LimitW-1:0] run_cnt_q, run_cnt_d, run_bumped;

  always_comb begin
    for (int i = 0; i < tcpq_pkg::NumClasses; i++) begin
      full[i]  = (counts_i[i] == CntW'(Depth));
      empty[i] = (counts_i[i] == '0);
    end
  end

  assign run_bumped = (run_cnt_q == tcpq_pkg::RunCountMax) ? run_cnt_q : run_cnt_q + 1'b1;

  always_comb begin
    ctrl_o        = '0;
    ctrl_o.served = tcpq_pkg::ClassNone;
    run_cnt_d     = run_cnt_q;
    if (cmd_valid_i) begin
      if (cmd_i.opcode == tcpq_pkg::OpEnqueue) begin
        unique case (tcpq_pkg::class_e'(cmd_i.queue_class))
          tcpq_pkg::ClassNormal: begin
            ctrl_o.push[tcpq_pkg::ClassNormal] = !full[tcpq_pkg::ClassNormal];
          end
          tcpq_pkg::ClassPriority: begin
            ctrl_o.push[tcpq_pkg::ClassPriority] = !full[tcpq_pkg::ClassPriority];
          end
          tcpq_pkg::ClassTop: begin
            ctrl_o.push[tcpq_pkg::ClassTop] = !full[tcpq_pkg::ClassTop];
          end
          default: begin
            ctrl_o.push = '0;
          end
        endcase
        ctrl_o.accepted = |ctrl_o.push;
      end else begin
        priority if (!empty[tcpq_pkg::ClassTop]) begin
          ctrl_o.served = tcpq_pkg::ClassTop;
        end else if (empty[tcpq_pkg::ClassNormal]) begin
          if (empty[tcpq_pkg::ClassPriority]) begin
            ctrl_o.nothing = 1'b1;
          end else begin
            ctrl_o.served = tcpq_pkg::ClassPriority;
            run_cnt_d     = run_bumped;
          end
        end else if (run_cnt_q >= run_limit_i || empty[tcpq_pkg::ClassPriority]) begin
          ctrl_o.served = tcpq_pkg::ClassNormal;
          run_cnt_d     = '0;
        end else begin
          ctrl_o.served = tcpq_pkg::ClassPriority;
          run_cnt_d     = run_bumped;
        end
        unique case (ctrl_o.served)
          tcpq_pkg::ClassNormal:   ctrl_o.pop[tcpq_pkg::ClassNormal]   = 1'b1;
          tcpq_pkg::ClassPriority: ctrl_o.pop[tcpq_pkg::ClassPriority] = 1'b1;
          tcpq_pkg::ClassTop:      ctrl_o.pop[tcpq_pkg::ClassTop]      = 1'b1;
          default:                 ctrl_o.pop                          = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q <= '0;
    end else begin
      run_cnt_q <= run_cnt_d;
    end
  end

endmodule

// ----- hdl/three_class_priority_queue_scheduler.sv -----
// Top level of the three-class priority queue scheduler.
//
//   port group            direction  transaction taken when
//   start_i / cmd_i       in         start_i high and busy_o low at the clock edge
//   done_o / rsp_o        out        done_o high; one cycle only, no back-pressure
//   psel .. prdata        in / out   psel, penable, pwrite and pready high
//
// One command per cycle; its result strobes after it passes the command register,
// then the decision and FIFO read into the result register.
// busy_o stays low: every command takes the same path through both registers.
// Reset clears FIFO pointers, fill counts and the run counter and loads a run
// limit of 3; FIFO storage is not cleared and needs no clearing pass.
module three_class_priority_queue_scheduler #(
  parameter int unsigned QueueDepth = tcpq_pkg::QueueDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  tcpq_pkg::cmd_t                  cmd_i,
  output logic                            busy_o,
  output logic                            done_o,
  output tcpq_pkg::rsp_t                  rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcpq_pkg::ApbAddrW-1:0]   paddr,
  input  logic [tcpq_pkg::ApbDataW-1:0]   pwdata,
  output logic [tcpq_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  `include "three_class_priority_queue_scheduler_macros.svh"

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned TotW = $clog2(tcpq_pkg::NumClasses * QueueDepth + 1);

  logic                                    cmd_valid_q;
  tcpq_pkg::cmd_t                          cmd_q;
  logic [tcpq_pkg::LimitW-1:0]             run_limit_q;
  logic                                    cfg_write;
  tcpq_pkg::ctrl_t                         ctrl;
  logic [tcpq_pkg::NumClasses-1:0][CntW-1:0] counts;
  logic signed [tcpq_pkg::DataW-1:0]       rdata [tcpq_pkg::NumClasses];
  logic [TotW-1:0]                         total_now, total_d;
  logic                                    done_q;
  tcpq_pkg::class_e                        served_q;
  logic                                    nothing_q;
  logic                                    accepted_q;
  logic [TotW-1:0]                         total_q;

  assign busy_o = 1'b0;
  assign pready = 1'b1;

  // Configuration
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == tcpq_pkg::RegIdxRunLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_limit_q <= tcpq_pkg::RunLimitReset;
    end else if (cfg_write) begin
      run_limit_q <= pwdata[tcpq_pkg::LimitW-1:0];
    end
  end

  assign prdata = (paddr[2] == tcpq_pkg::RegIdxRunLimit) ?
                  tcpq_pkg::ApbDataW'(run_limit_q) : '0;

  // Command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      cmd_q <= cmd_i;
    end
  end

  tcpq_arbiter #(
    .Depth(QueueDepth)
  ) u_arbiter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid_q),
    .cmd_i      (cmd_q),
    .counts_i   (counts),
    .run_limit_i(run_limit_q),
    .ctrl_o     (ctrl)
  );

  for (genvar g = 0; g < tcpq_pkg::NumClasses; g++) begin : gen_fifo
    tcpq_fifo #(
      .Depth(QueueDepth)
    ) u_fifo (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .push_i (ctrl.push[g]),
      .pop_i  (ctrl.pop[g]),
      .wdata_i(cmd_q.entry_value),
      .rdata_o(rdata[g]),
      .count_o(counts[g])
    );
  end

  // Occupancy after this command
  always_comb begin
    total_now = '0;
    for (int i = 0; i < tcpq_pkg::NumClasses; i++) begin
      total_now = total_now + TotW'(counts[i]);
    end
    total_d = total_now + TotW'(ctrl.accepted) - TotW'(|ctrl.pop);
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_q) begin
      served_q   <= ctrl.served;
      nothing_q  <= ctrl.nothing;
      accepted_q <= ctrl.accepted;
      total_q    <= total_d;
    end
  end

  assign done_o = done_q;

  always_comb begin
    rsp_o                  = '0;
    rsp_o.served_class     = served_q;
    rsp_o.nothing_to_serve = nothing_q;
    rsp_o.entry_accepted   = accepted_q;
    rsp_o.all_empty        = (total_q == '0);
    rsp_o.total_occupancy  = tcpq_pkg::OccW'(total_q);
    unique case (served_q)
      tcpq_pkg::ClassNormal:   rsp_o.out_value = rdata[tcpq_pkg::ClassNormal];
      tcpq_pkg::ClassPriority: rsp_o.out_value = rdata[tcpq_pkg::ClassPriority];
      tcpq_pkg::ClassTop:      rsp_o.out_value = rdata[tcpq_pkg::ClassTop];
      default: rsp_o.out_value = nothing_q ? tcpq_pkg::EmptyValue : '0;
    endcase
  end

  `TCPQ_ASSERT(a_done_follows_start, clk_i, rst_ni, done_o |-> $past(start_i, 2))
  `TCPQ_ASSERT(a_nothing_means_empty, clk_i, rst_ni,
               (done_o && nothing_q) |-> (total_q == '0 && served_q == tcpq_pkg::ClassNone))
  `TCPQ_ASSERT(a_accept_not_empty, clk_i, rst_ni, (done_o && accepted_q) |-> (total_q != '0))
  `TCPQ_ASSERT_NEVER(a_total_in_range, clk_i, rst_ni,
                     done_o && (total_q > TotW'(tcpq_pkg::NumClasses * QueueDepth)))

endmodule

// ----- dv/tcpq_checker.sv -----
// Scheduler checker: predicts command results and run-limit reads, compares them with the DUT.
module tcpq_checker
  import tcpq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  cmd_t                cmd_i,
  input  logic                done_i,
  input  rsp_t                rsp_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  input  logic [ApbDataW-1:0] prdata_i,
  input  logic                pready_i,
  output int unsigned         err_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned MaxReports = 10;
  localparam logic [ApbAddrW-1:0] RunLimitAddr = ApbAddrW'(4 * RegIdxRunLimit);

  logic signed [DataW-1:0] entry_store [NumClasses][QueueDepth];
  int unsigned             rd_ptr [NumClasses];
  int unsigned             wr_ptr [NumClasses];
  int unsigned             fill [NumClasses];
  logic [LimitW-1:0]       run_count;
  logic [LimitW-1:0]       run_limit;
  rsp_t                    sched_rsps_q [$];
  rsp_t                    want;

  task automatic note_mismatch(input string field, input int expv, input int gotv);
    if (err_count_o < MaxReports) begin
      $display("mismatch on %s: expected %0d, got %0d", field, expv, gotv);
    end
    err_count_o++;
  endtask

  function automatic rsp_t schedule_cmd(input cmd_t c);
    rsp_t        r;
    class_e      srv;
    int unsigned total;
    r   = '0;
    srv = ClassNone;
    if (op_e'(c.opcode) == OpEnqueue) begin
      if (class_e'(c.queue_class) != ClassNone && fill[c.queue_class] < QueueDepth) begin
        entry_store[c.queue_class][wr_ptr[c.queue_class]] = c.entry_value;
        wr_ptr[c.queue_class] = (wr_ptr[c.queue_class] + 1) % QueueDepth;
        fill[c.queue_class]++;
        r.entry_accepted = 1'b1;
      end
    end else begin
      if (fill[ClassTop] != 0) begin
        srv = ClassTop;
      end else if (fill[ClassNormal] == 0) begin
        if (fill[ClassPriority] == 0) begin
          r.nothing_to_serve = 1'b1;
          r.out_value        = EmptyValue;
        end else begin
          srv = ClassPriority;
        end
      end else if (run_count >= run_limit || fill[ClassPriority] == 0) begin
        srv       = ClassNormal;
        run_count = '0;
      end else begin
        srv = ClassPriority;
      end
      if (srv == ClassPriority && run_count != RunCountMax) begin
        run_count++;
      end
      if (srv != ClassNone) begin
        r.out_value = entry_store[srv][rd_ptr[srv]];
        rd_ptr[srv] = (rd_ptr[srv] + 1) % QueueDepth;
        fill[srv]--;
      end
    end
    r.served_class    = srv;
    total             = fill[ClassNormal] + fill[ClassPriority] + fill[ClassTop];
    r.all_empty       = (total == 0);
    r.total_occupancy = OccW'(total);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumClasses; i++) begin
        rd_ptr[i] = 0;
        wr_ptr[i] = 0;
        fill[i]   = 0;
      end
      run_count = '0;
      run_limit = RunLimitReset;
      sched_rsps_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == RunLimitAddr) begin
        if (pwrite_i) begin
          run_limit = pwdata_i[LimitW-1:0];
        end else if (prdata_i !== ApbDataW'(run_limit)) begin
          note_mismatch("prdata", run_limit, prdata_i);
        end
      end
      if (start_i && !busy_i) begin
        sched_rsps_q.push_back(schedule_cmd(cmd_i));
      end
      if (done_i) begin
        if (sched_rsps_q.size() == 0) begin
          if (err_count_o < MaxReports) begin
            $display("unexpected result: out_value %0d served_class %0d",
                     rsp_i.out_value, rsp_i.served_class);
          end
          err_count_o++;
        end else begin
          want = sched_rsps_q.pop_front();
          if (rsp_i.out_value !== want.out_value)
            note_mismatch("out_value", want.out_value, rsp_i.out_value);
          if (rsp_i.served_class !== want.served_class)
            note_mismatch("served_class", want.served_class, rsp_i.served_class);
          if (rsp_i.nothing_to_serve !== want.nothing_to_serve)
            note_mismatch("nothing_to_serve", want.nothing_to_serve, rsp_i.nothing_to_serve);
          if (rsp_i.entry_accepted !== want.entry_accepted)
            note_mismatch("entry_accepted", want.entry_accepted, rsp_i.entry_accepted);
          if (rsp_i.all_empty !== want.all_empty)
            note_mismatch("all_empty", want.all_empty, rsp_i.all_empty);
          if (rsp_i.total_occupancy !== want.total_occupancy)
            note_mismatch("total_occupancy", want.total_occupancy, rsp_i.total_occupancy);
        end
      end
      pending_o = sched_rsps_q.size();
    end
  end

endmodule

// ----- dv/three_class_priority_queue_scheduler_test.sv -----
// Scheduler testbench top: clock, reset, command and register stimulus, watchdog and verdict.
module three_class_priority_queue_scheduler_test;
  import tcpq_pkg::*;

  localparam int unsigned StallLimit = 500;
  localparam logic [ApbAddrW-1:0] RunLimitAddr = ApbAddrW'(4 * RegIdxRunLimit);

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  cmd_t                cmd_i;
  logic                busy;
  logic                done;
  rsp_t                rsp;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  int unsigned         err_count;
  int unsigned         pending;
  int unsigned         items_sent;
  int unsigned         stall_cycles;
  bit                  gaps_on;

  three_class_priority_queue_scheduler u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy),
    .done_o  (done),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tcpq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy),
    .cmd_i       (cmd_i),
    .done_i      (done),
    .rsp_i       (rsp),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start_i && !busy) || done || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send(input op_e op, input class_e cls, input logic [DataW-1:0] val);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i             <= 1'b1;
    cmd_i.opcode        <= op;
    cmd_i.queue_class   <= cls;
    cmd_i.entry_value   <= val;
    do @(posedge clk_i); while (busy);
    if (op == OpDequeue || cls != ClassNone) items_sent++;
  endtask

  task automatic apb_access(input logic wr, input logic [ApbDataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= RunLimitAddr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(input logic [LimitW-1:0] lim);
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    apb_access(1'b1, ApbDataW'(lim));
    apb_access(1'b0, '0);
  endtask

  task automatic priority_churn(input int unsigned pairs, input bit with_normal);
    repeat (pairs) begin
      if (with_normal && $urandom_range(0, 7) == 0) send(OpEnqueue, ClassNormal, 8'($urandom));
      send(OpEnqueue, ClassPriority, 8'($urandom));
      send(OpDequeue, class_e'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  task automatic run_traffic(input int unsigned n_items, input bit tail);
    int unsigned target;
    int unsigned len;
    class_e      cls;
    target = items_sent + n_items;
    while (items_sent < target) begin
      gaps_on = !tail && $urandom_range(0, 3) != 0;
      len     = $urandom_range(4, 20);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          cls = class_e'($urandom_range(0, 2));
          repeat (len) begin
            send(OpEnqueue, ($urandom_range(0, 15) == 0) ? ClassNone : cls, 8'($urandom));
          end
        end
        3, 4, 5: begin
          repeat (len + 4) send(OpDequeue, class_e'($urandom_range(0, 3)), 8'($urandom));
        end
        6, 7, 8: begin
          repeat (len) begin
            send(op_e'($urandom_range(0, 1)), class_e'($urandom_range(0, 3)), 8'($urandom));
          end
        end
        default: begin
          priority_churn(len, 1'b1);
        end
      endcase
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    cmd_i      = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    gaps_on    = 1'b0;
    items_sent = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    apb_access(1'b0, '0);

    send(OpDequeue, ClassNone, 8'h00);
    send(OpEnqueue, ClassNone, 8'h7F);
    send(OpEnqueue, ClassNormal, 8'h80);
    send(OpEnqueue, ClassNormal, 8'h7F);
    send(OpEnqueue, ClassPriority, 8'h55);
    send(OpEnqueue, ClassPriority, 8'hFF);
    send(OpEnqueue, ClassPriority, 8'h00);
    send(OpEnqueue, ClassPriority, 8'h2A);
    send(OpEnqueue, ClassTop, 8'hAA);
    send(OpDequeue, ClassTop, 8'hFF);
    send(OpDequeue, ClassNormal, 8'h00);
    send(OpDequeue, ClassPriority, 8'h80);
    send(OpDequeue, ClassNone, 8'h7F);
    send(OpDequeue, ClassNormal, 8'h01);
    send(OpDequeue, ClassPriority, 8'hFE);
    send(OpDequeue, ClassTop, 8'h00);
    send(OpDequeue, ClassNormal, 8'h00);
    send(OpEnqueue, ClassNormal, 8'h01);
    send(OpDequeue, ClassNone, 8'hFF);
    send(OpDequeue, ClassNormal, 8'h00);

    set_limit(8'd0);
    run_traffic(200, 1'b0);
    set_limit(8'd255);
    gaps_on = 1'b1;
    repeat (50) send(OpDequeue, class_e'($urandom_range(0, 3)), 8'($urandom));
    priority_churn(270, 1'b0);
    run_traffic(150, 1'b0);
    set_limit(8'd1);
    run_traffic(200, 1'b0);
    set_limit(8'($urandom_range(2, 254)));
    run_traffic(200, 1'b0);
    set_limit(RunLimitReset);
    run_traffic(150, 1'b0);
    set_limit(8'($urandom));
    run_traffic(200, 1'b1);

    @(negedge clk_i);
    start_i <= 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
